// ===== hw/rtl/sorted_table_search_macros.svh =====
// Assertion macros shared by the table search RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef SORTED_TABLE_SEARCH_MACROS_SVH
`define SORTED_TABLE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sts assertion failed");

// Next-cycle implication.
`define STS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sts assertion failed");

`else

`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

    localparam int STS_TABLE_DEPTH = 1024;

    localparam int VALUE_W = 32;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 11;
    localparam int POS_W   = 10;
    localparam int PROBE_W = 11;

    // configuration register indexes
    localparam logic [0:0] REG_SEARCH_MODE = 1'b0;
    localparam logic [0:0] REG_TABLE_SIZE  = 1'b1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [PROBE_W-1:0] probe_count;
    } sts_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sts_entry_ram.sv =====
`default_nettype none

module sts_entry_ram #(
    parameter int TABLE_DEPTH = sts_pkg::STS_TABLE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]      waddr,
    input  wire logic [sts_pkg::VALUE_W-1:0]         wdata,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]      raddr,
    output logic      [sts_pkg::VALUE_W-1:0]         rdata
);
    import sts_pkg::*;

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sts_search_unit.sv =====
`default_nettype none

`include "sorted_table_search_macros.svh"

module sts_search_unit #(
    parameter int TABLE_DEPTH = sts_pkg::STS_TABLE_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 mode,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]     n,
    input  wire logic [sts_pkg::VALUE_W-1:0]          target,
    input  wire logic [sts_pkg::VALUE_W-1:0]          rdata,
    output logic      [$clog2(TABLE_DEPTH)-1:0]       raddr,
    output logic                                      idle,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output sts_pkg::sts_result_t                      result
);
    import sts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ISSUE   = 4'b0010,
        ST_COMPARE = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      probes_reg, probes_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic               found_reg, found_next;
    logic               mode_reg, mode_next;
    logic [VALUE_W-1:0] target_reg, target_next;

    logic [CW-1:0]      mid;
    logic               hit;
    logic               below;
    logic [31:0]        pos_ext;
    logic [31:0]        probes_ext;

    // midpoint of the inclusive range [lo, hi-1]; linear scan probes lo
    assign mid   = (mode_reg == MODE_BINARY) ? lo_reg + ((hi_reg - CW'(1) - lo_reg) >> 1)
                                             : lo_reg;
    assign raddr = mid[AW-1:0];

    // equality and signed less-than comparators; linear mode uses only the equality result
    assign hit   = (rdata == target_reg);
    assign below = ($signed(rdata) < $signed(target_reg));

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        n_next      = n_reg;
        probes_next = probes_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        mode_next   = mode_reg;
        target_next = target_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    lo_next     = '0;
                    hi_next     = n;
                    n_next      = n;
                    probes_next = '0;
                    pos_next    = '0;
                    found_next  = 1'b0;
                    mode_next   = mode;
                    target_next = target;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = (lo_reg < hi_reg) ? ST_COMPARE : ST_DONE;
            end
            ST_COMPARE:
            begin
                probes_next = probes_reg + CW'(1);
                if (hit)
                begin
                    found_next = 1'b1;
                    pos_next   = mid[AW-1:0];
                    state_next = ST_DONE;
                end
                else
                begin
                    if (mode_reg == MODE_LINEAR || below)
                    begin
                        lo_next = mid + CW'(1);
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lo_reg     <= '0;
            hi_reg     <= '0;
            n_reg      <= '0;
            probes_reg <= '0;
            found_reg  <= 1'b0;
            mode_reg   <= MODE_BINARY;
        end
        else
        begin
            state_reg  <= state_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            n_reg      <= n_next;
            probes_reg <= probes_next;
            found_reg  <= found_next;
            mode_reg   <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        target_reg <= target_next;
    end

    assign pos_ext    = 32'(pos_reg);
    assign probes_ext = 32'(probes_reg);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        result.found       = found_reg;
        result.position    = found_reg ? pos_ext[POS_W-1:0] : '0;
        result.probe_count = probes_ext[PROBE_W-1:0];
    end

    `STS_ASSERT_IMP(a_cmp_after_issue, clk, rst_n, state_reg == ST_COMPARE, $past(state_reg) == ST_ISSUE)
    `STS_ASSERT_IMP(a_range_ordered, clk, rst_n, state_reg != ST_IDLE, lo_reg <= hi_reg)
    `STS_ASSERT_IMP(a_probes_bounded, clk, rst_n, state_reg != ST_IDLE, probes_reg <= n_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_table_search.sv =====
// Channel    Dir  Handshake            Payload
// s_*        in   s_tvalid/s_tready    tuser: cmd; tdata: entry_index, value
// m_*        out  m_tvalid/m_tready    tuser: found; tdata: position, probe_count
// cfg_*      in   cfg_we               cfg_index selects search_mode or table_size
//
// A write transfer leaves the block ready.
// A search holds s_tready low while the search unit steps through ISSUE (the registered RAM
// read) and COMPARE (the comparator) for each entry probed, then waits in DONE.
// Binary mode probes at most clog2(TABLE_DEPTH)+1 entries, linear mode up to min(table_size, TABLE_DEPTH).
// A result stalled on m_tready holds the search in its final state, s_tready low, until the
// output register frees up. Reset sets search_mode to binary and table_size to zero.
`default_nettype none

`include "sorted_table_search_macros.svh"

module sorted_table_search #(
    parameter int TABLE_DEPTH = sts_pkg::STS_TABLE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // slave stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [47:0]                  s_tdata,   // [9:0] entry_index, [41:10] value
    input  wire logic                         s_tuser,   // [0] cmd
    // master stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [23:0]                  m_tdata,   // [9:0] position, [20:10] probe_count
    output logic                              m_tuser,   // [0] found
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [sts_pkg::CFG_W-1:0]    cfg_wdata
);
    import sts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // configuration registers
    logic               search_mode_reg;
    logic [CFG_W-1:0]   table_size_reg;

    // unpacked input payload
    logic               cmd;
    logic [IDX_W-1:0]   entry_index;
    logic [VALUE_W-1:0] value;

    logic               s_xfer;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic               search_start;
    logic [CW-1:0]      n_eff;

    logic               unit_idle;
    logic               res_valid;
    logic               res_ready;
    sts_result_t        unit_result;

    logic               m_tvalid_reg;
    sts_result_t        out_reg;

    assign cmd         = s_tuser;
    assign entry_index = s_tdata[IDX_W-1:0];
    assign value       = s_tdata[IDX_W+VALUE_W-1:IDX_W];

    // configuration is to be written only while the block is idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= MODE_BINARY;
            table_size_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEARCH_MODE: search_mode_reg <= cfg_wdata[0];
                REG_TABLE_SIZE:  table_size_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // accept items only while the search unit is idle
    assign s_tready = unit_idle;
    assign s_xfer   = s_tvalid && s_tready;

    // drop writes that fall beyond the table
    assign ram_we       = s_xfer && (cmd == CMD_WRITE) &&
                          (32'(entry_index) < 32'(TABLE_DEPTH));
    assign search_start = s_xfer && (cmd == CMD_SEARCH);

    // saturate the search range to the table depth
    assign n_eff = (32'(table_size_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(table_size_reg);

    sts_entry_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(entry_index)),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sts_search_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (search_start),
        .mode      (search_mode_reg),
        .n         (n_eff),
        .target    (value),
        .rdata     (ram_rdata),
        .raddr     (ram_raddr),
        .idle      (unit_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (unit_result)
    );

    // output register: load a finished result whenever the slot is free or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= unit_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {3'b000, out_reg.probe_count, out_reg.position};

    `STS_ASSERT_NXT(a_busy_after_search, clk, rst_n, search_start, !s_tready)
    `STS_ASSERT_IMP(a_load_from_unit, clk, rst_n, $rose(m_tvalid_reg), $past(res_valid))
    `STS_ASSERT_IMP(a_miss_pos_zero, clk, rst_n, m_tvalid_reg && !out_reg.found, out_reg.position == '0)

endmodule

`default_nettype wire

// ===== tb/sorted_table_search_test.sv =====
`timescale 1ns / 1ps

module sorted_table_search_test;
    import sts_pkg::*;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Mirror of the table and the two registers, plus the queue of search
    // answers still owed by the block.
    class search_scoreboard;
        logic signed [VALUE_W-1:0] entries [STS_TABLE_DEPTH];
        logic                      mode = MODE_BINARY;
        int unsigned               size = 0;
        sts_result_t               pending_results [$];
        int                        failures = 0;
        int                        searches = 0;
        int                        hits     = 0;

        function void note_register(logic [0:0] index, logic [CFG_W-1:0] data);
            if (index == REG_SEARCH_MODE)
                mode = data[0];
            else
                size = data;
        endfunction

        // Walk the same probe sequence the block should follow.
        function sts_result_t lookup(logic signed [VALUE_W-1:0] target);
            sts_result_t r;
            int unsigned span, lo, hi, mid, probes;
            r = '0;
            probes = 0;
            span = (size > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : size;
            if (mode == MODE_LINEAR) begin
                lo = 0;
                while (lo < span && !r.found) begin
                    probes++;
                    if (entries[lo] == target) begin
                        r.found = 1'b1;
                        r.position = lo[POS_W-1:0];
                    end
                    lo++;
                end
            end
            else begin
                lo = 0;
                hi = span;
                while (lo < hi && !r.found) begin
                    mid = lo + (hi - 1 - lo) / 2;
                    probes++;
                    if (entries[mid] == target) begin
                        r.found = 1'b1;
                        r.position = mid[POS_W-1:0];
                    end
                    else if (entries[mid] < target)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
            end
            r.probe_count = probes[PROBE_W-1:0];
            return r;
        endfunction

        function void note_transfer(logic cmd, logic [IDX_W-1:0] index,
                                    logic signed [VALUE_W-1:0] value);
            sts_result_t r;
            if (cmd == CMD_WRITE) begin
                entries[index] = value;
            end
            else begin
                r = lookup(value);
                pending_results.push_back(r);
                searches++;
                if (r.found)
                    hits++;
            end
        endfunction

        function void check_result(logic found, logic [POS_W-1:0] position,
                                   logic [PROBE_W-1:0] probe_count);
            sts_result_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with no search outstanding");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, found);
                failures++;
            end
            if (position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, position);
                failures++;
            end
            if (probe_count !== want.probe_count) begin
                $error("probe_count: expected %0d, actual %0d",
                       want.probe_count, probe_count);
                failures++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata = '0;    // [9:0] entry_index, [41:10] value
    logic               s_tuser = 1'b0;  // [0] cmd
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;         // [9:0] position, [20:10] probe_count
    logic               m_tuser;         // [0] found
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    search_scoreboard   sb;
    int                 idle_pct = 22;   // share of idle cycles on both sides
    int                 item_count = 0;

    sorted_table_search #(
        .TABLE_DEPTH (STS_TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Receiver: stall at random, drive on the falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[POS_W-1:0], m_tdata[POS_W +: PROBE_W]);
    end

    // Offer one item, with random gaps ahead of it, and hold it until the
    // transfer. Leave tvalid high afterwards; the next call replaces or drops it, settle() drops it.
    task automatic push_item(input logic cmd, input logic [IDX_W-1:0] index,
                             input logic signed [VALUE_W-1:0] value);
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, value, index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_transfer(cmd, index, value);
        item_count++;
    endtask

    // Drop tvalid and wait for every owed result, then a short tail so a
    // trailing write has left the pipeline too.
    task automatic settle(input int tail);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.note_register(index, data);
    endtask

    task automatic set_mode(input logic mode);
        write_reg(REG_SEARCH_MODE, {{(CFG_W-1){1'b0}}, mode});
    endtask

    task automatic set_size(input int n);
        write_reg(REG_TABLE_SIZE, n[CFG_W-1:0]);
    endtask

    // Write entries 0..n-1 in ascending order. Dense steps give many
    // duplicates; wide steps spread the values over the whole signed range.
    task automatic fill_sorted(input int n, input bit dense, input bit pin_ends);
        longint cur, step_max;
        step_max = dense ? 64'sd3 : (64'sd8589934592 / (n + 1));
        if (pin_ends)
            cur = VAL_MIN;
        else if (dense)
            cur = longint'(int'($urandom));
        else
            cur = VAL_MIN + longint'($urandom) % (step_max + 1);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                cur += longint'($urandom) % (step_max + 1);
            if (cur > VAL_MAX)
                cur = VAL_MAX;
            if (pin_ends && i == n - 1)
                cur = VAL_MAX;
            push_item(CMD_WRITE, i[IDX_W-1:0], cur[VALUE_W-1:0]);
        end
    endtask

    // Unordered contents: binary mode then follows a path that may miss.
    task automatic fill_scrambled(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                push_item(CMD_WRITE, i[IDX_W-1:0], $urandom_range(0, 7));
            else
                push_item(CMD_WRITE, i[IDX_W-1:0], $urandom);
        end
    endtask

    // Mostly targets taken from the live part of the table, then near misses,
    // random words and the two extremes; optionally sprinkle stray writes.
    task automatic run_searches(input int count, input int n, input bit noise);
        int r, span;
        logic signed [VALUE_W-1:0] target;
        span = (n > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : n;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (noise && r < 12) begin
                push_item(CMD_WRITE, IDX_W'($urandom_range(0, STS_TABLE_DEPTH - 1)),
                          $urandom);
            end
            else begin
                r = $urandom_range(0, 99);
                if (span > 0 && r < 55)
                    target = sb.entries[$urandom_range(0, span - 1)];
                else if (span > 0 && r < 70)
                    target = sb.entries[$urandom_range(0, span - 1)]
                             + (r[0] ? 32'sd1 : -32'sd1);
                else if (r < 85)
                    target = $urandom;
                else if (r < 92)
                    target = VAL_MIN;
                else
                    target = VAL_MAX;
                push_item(CMD_SEARCH, IDX_W'($urandom), target);
            end
        end
    endtask

    initial
    begin
        logic signed [VALUE_W-1:0] seed_row [8];
        int n, r, phase, span;
        logic mode;

        seed_row = '{VAL_MIN, -32'sd5, -32'sd1, 32'sd0, 32'sd2, 32'sd2, 32'sd77, VAL_MAX};
        sb = new;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Right out of reset the table is empty, so a search
        // must answer not found with no probes.
        push_item(CMD_SEARCH, '0, 32'sd5);
        for (int i = 0; i < 8; i++)
            push_item(CMD_WRITE, i[IDX_W-1:0], seed_row[i]);
        settle(4);
        // Mode is left at its reset value: binary.
        set_size(8);
        push_item(CMD_SEARCH, '0, VAL_MIN);
        push_item(CMD_SEARCH, '1, VAL_MAX);
        push_item(CMD_SEARCH, '0, 32'sd2);
        push_item(CMD_SEARCH, '0, 32'sd0);
        push_item(CMD_SEARCH, '0, -32'sd3);
        push_item(CMD_SEARCH, '0, 32'sd100);
        settle(4);
        // Linear scan: first of two duplicates, last entry, full miss.
        set_mode(MODE_LINEAR);
        push_item(CMD_SEARCH, '0, 32'sd2);
        push_item(CMD_SEARCH, '0, VAL_MAX);
        push_item(CMD_SEARCH, '0, 32'sd5);
        settle(4);
        set_size(0);
        push_item(CMD_SEARCH, '0, 32'sd0);
        // Break the order and search in binary mode: 77 is present yet missed.
        push_item(CMD_WRITE, 10'd3, 32'sd1000);
        settle(4);
        set_mode(MODE_BINARY);
        set_size(8);
        push_item(CMD_SEARCH, '0, -32'sd5);
        push_item(CMD_SEARCH, '0, 32'sd1000);
        push_item(CMD_SEARCH, '0, 32'sd77);
        settle(4);

        // Full-depth table, written with no idling on either side. This also
        // makes every entry valid for all later phases.
        item_count = 0;
        idle_pct = 0;
        fill_sorted(STS_TABLE_DEPTH, 1'b0, 1'b1);
        idle_pct = 22;
        settle(4);
        set_size(STS_TABLE_DEPTH);
        run_searches(16, STS_TABLE_DEPTH, 1'b0);
        settle(4);
        // Oversized size register saturates to the depth.
        set_size(2047);
        run_searches(10, 2047, 1'b0);
        settle(4);
        set_mode(MODE_LINEAR);
        run_searches(3, 2047, 1'b0);
        settle(4);
        set_size(STS_TABLE_DEPTH + 1);
        run_searches(2, STS_TABLE_DEPTH + 1, 1'b0);

        // Random phases: new mode and size each time, mostly small sorted
        // tables, some scrambled, some reusing what is already stored.
        phase = 0;
        while (item_count < 1150) begin
            settle(4);
            idle_pct = (phase % 7 == 3) ? 0 : 22;
            r = $urandom_range(0, 99);
            if (r < 5)
                n = 0;
            else if (r < 9)
                n = STS_TABLE_DEPTH;
            else if (r < 12)
                n = $urandom_range(STS_TABLE_DEPTH + 1, 2047);
            else if (r < 80)
                n = $urandom_range(1, 40);
            else
                n = $urandom_range(41, 300);
            mode = ($urandom_range(0, 99) < 60) ? MODE_BINARY : MODE_LINEAR;
            span = (n > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : n;
            set_mode(mode);
            set_size(n);
            if (n > 0 && n <= 300) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    fill_sorted(n, $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
                else if (r < 85)
                    fill_scrambled(n);
            end
            run_searches((span > 300) ? 4 : $urandom_range(10, 25), n, 1'b1);
            phase++;
        end

        settle(40);
        $display("Run covered %0d items after the directed part and %0d searches in all",
                 item_count, sb.searches);
        $display("(%0d hits), both modes, table sizes from 0 up to 2047.", sb.hits);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sts_entry_ram.sv
hw/rtl/sts_search_unit.sv
hw/rtl/sorted_table_search.sv
tb/sorted_table_search_test.sv
